FILE: rtl/core/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants of the grid ray caster
// Field widths, fixed-point formats, register indexes, and the command and
// status records between the controller and the datapath.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int SCREEN_W_DEF = 640;
  localparam int SCREEN_H_DEF = 480;
  localparam int MAP_SIDE_DEF = 64;

  localparam int COL_W  = 10;
  localparam int CELL_W = 6;
  localparam int VAL_W  = 8;
  localparam int POS_W  = 24;
  localparam int VEC_W  = 18;
  localparam int DIST_W = 24;
  localparam int ROW_W  = 9;
  localparam int FRAC_W = 16;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // internal fixed-point widths
  localparam int NUM_W = 48;  // divider dividend / quotient
  localparam int DEN_W = 32;  // divider divisor
  localparam int CAM_W = 28;  // signed camera offset, Q.16
  localparam int RD_W  = 31;  // signed ray component, Q.16
  localparam int DD_W  = 41;  // step length, up to 2^40
  localparam int SD_W  = 53;  // side distance accumulators
  localparam int PN_W  = 27;  // signed perpendicular numerator
  localparam int HT_W  = 29;  // wall height

  localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

  // configuration register indexes
  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;

  // divider operand selects
  localparam logic [2:0] DS_CAM  = 3'd0;
  localparam logic [2:0] DS_DDX  = 3'd1;
  localparam logic [2:0] DS_DDY  = 3'd2;
  localparam logic [2:0] DS_PERP = 3'd3;
  localparam logic [2:0] DS_H    = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [VEC_W-1:0] dir_x;
    logic [VEC_W-1:0] dir_y;
    logic [VEC_W-1:0] plane_x;
    logic [VEC_W-1:0] plane_y;
  } cfg_t;

  typedef struct packed {
    logic       clr;
    logic       wr_map;
    logic       ld_item;
    logic       div_start;
    logic [2:0] div_sel;
    logic       ld_cam;
    logic       ld_ray;
    logic       ld_ddx;
    logic       ld_ddy;
    logic       ld_sd;
    logic       step;
    logic       ld_hit;
    logic       ld_dist;
    logic       ld_h;
    logic       ld_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic stop;
    logic oob;
    logic cell_nz;
    logic out_full;
  } sts_t;

endpackage

FILE: rtl/core/grc_ifs.sv
// ----------------------------------------------------------------------------
// grc_ifs: channel interfaces of the grid ray caster
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface grc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [grc_pkg::COL_W-1:0]   column;
  logic [grc_pkg::CELL_W-1:0]  cell_x;
  logic [grc_pkg::CELL_W-1:0]  cell_y;
  logic [grc_pkg::VAL_W-1:0]   cell_value;

  modport source (output valid, opcode, column, cell_x, cell_y, cell_value, input ready);
  modport sink   (input valid, opcode, column, cell_x, cell_y, cell_value, output ready);
endinterface

interface grc_out_if;
  logic                        valid;
  logic                        ready;
  logic [grc_pkg::COL_W-1:0]   out_column;
  logic [grc_pkg::CELL_W-1:0]  hit_x;
  logic [grc_pkg::CELL_W-1:0]  hit_y;
  logic [grc_pkg::VAL_W-1:0]   hit_value;
  logic                        hit_side;
  logic                        escaped;
  logic [grc_pkg::DIST_W-1:0]  wall_dist;
  logic [grc_pkg::ROW_W-1:0]   wall_start;
  logic [grc_pkg::ROW_W-1:0]   wall_end;

  modport source (output valid, out_column, hit_x, hit_y, hit_value, hit_side, escaped,
                  wall_dist, wall_start, wall_end, input ready);
  modport sink   (input valid, out_column, hit_x, hit_y, hit_value, hit_side, escaped,
                  wall_dist, wall_start, wall_end, output ready);
endinterface

FILE: rtl/core/grc_ram.sv
// ----------------------------------------------------------------------------
// grc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: rtl/core/grc_div.sv
// ----------------------------------------------------------------------------
// grc_div: radix-2 restoring divider
// One quotient bit per cycle; done holds until the next start.
// ----------------------------------------------------------------------------
module grc_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             ge;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      quo_r  <= num;
      rem_r  <= '0;
      den_r  <= den;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;
endmodule

FILE: rtl/core/grc_dp.sv
// ----------------------------------------------------------------------------
// grc_dp: ray caster datapath
// Ray setup, DDA walk registers, shared divider, result register.
// ----------------------------------------------------------------------------
module grc_dp #(
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480,
  parameter int MAP_SIDE = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  grc_pkg::cmd_t                           cmd,
  output grc_pkg::sts_t                           sts,
  input  grc_pkg::cfg_t                           cfg,
  input  logic [grc_pkg::COL_W-1:0]               in_column,
  input  logic [grc_pkg::CELL_W-1:0]              in_cell_x,
  input  logic [grc_pkg::CELL_W-1:0]              in_cell_y,
  input  logic [grc_pkg::VAL_W-1:0]               in_cell_value,
  output logic                                    ram_we,
  output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]    ram_waddr,
  output logic [grc_pkg::VAL_W-1:0]               ram_wdata,
  output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]    ram_raddr,
  input  logic [grc_pkg::VAL_W-1:0]               ram_rdata,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [grc_pkg::COL_W-1:0]               out_column,
  output logic [grc_pkg::CELL_W-1:0]              hit_x,
  output logic [grc_pkg::CELL_W-1:0]              hit_y,
  output logic [grc_pkg::VAL_W-1:0]               hit_value,
  output logic                                    hit_side,
  output logic                                    escaped,
  output logic [grc_pkg::DIST_W-1:0]              wall_dist,
  output logic [grc_pkg::ROW_W-1:0]               wall_start,
  output logic [grc_pkg::ROW_W-1:0]               wall_end
);
  import grc_pkg::*;

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LIMIT = 4 * MAP_SIDE + 4;
  localparam int CNT_W = $clog2(LIMIT + 1);
  localparam int M_W   = 10;
  localparam int HALF  = SCREEN_H / 2;
  localparam int FR_W  = FRAC_W + 1;
  localparam int MUL_W = FR_W + 33;
  // camera offset: column * 2^17 / SCREEN_W by reciprocal multiplication,
  // exact for every 10-bit column
  localparam int     CAM_SH = 22;
  localparam longint CAM_M  = ((64'sd1 <<< (FRAC_W + 1 + CAM_SH)) + SCREEN_W - 1) / SCREEN_W;
  localparam int     CMUL_W = COL_W + FRAC_W + 1 + CAM_SH;

  // clear sweep
  logic [AW-1:0] clr_r;
  // cast state
  logic [COL_W-1:0]        col_r;
  logic signed [CAM_W-1:0] cam_r;
  logic signed [RD_W-1:0]  rdx_r, rdy_r;
  logic [DD_W-1:0]         ddx_r, ddy_r;
  logic [SD_W-1:0]         sdx_r, sdy_r;
  logic signed [M_W-1:0]   mx_r, my_r;
  logic                    side_r;
  logic                    esc_r;
  logic                    hit_r;
  logic [VAL_W-1:0]        val_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [DIST_W-1:0]       dist_r;
  logic [HT_W-1:0]         h_r;
  logic                    out_valid_r;

  logic                    map_ok;
  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic [NUM_W-1:0]        div_quo;
  logic                    div_done;

  logic [CMUL_W-1:0]       cam_mul;
  logic [RD_W-1:0]         abs_rdx, abs_rdy;
  logic signed [VEC_W+CAM_W-1:0] prod_x, prod_y;
  logic [FR_W-1:0]         frac_x, frac_y;
  logic [MUL_W-1:0]        mul_x, mul_y;
  logic signed [PN_W-1:0]  pn_x, pn_y, pn_sel;
  logic signed [RD_W-1:0]  rd_sel;
  logic [PN_W-1:0]         pn_abs;
  logic [DIST_W-1:0]       dist_nxt;
  logic [HT_W-1:0]         hh;
  logic [HT_W:0]           ws_w, we_w;
  logic [7:0]              pxi, pyi;

  assign map_ok = (int'(in_cell_x) < MAP_SIDE) && (int'(in_cell_y) < MAP_SIDE);

  assign ram_we    = cmd.clr | (cmd.wr_map & map_ok);
  assign ram_waddr = cmd.clr ? clr_r : AW'(int'(in_cell_x) * MAP_SIDE + int'(in_cell_y));
  assign ram_wdata = cmd.clr ? '0 : in_cell_value;
  assign ram_raddr = AW'(int'(mx_r[M_W-2:0]) * MAP_SIDE + int'(my_r[M_W-2:0]));

  assign cam_mul = CMUL_W'(col_r) * CMUL_W'(CAM_M);

  assign abs_rdx = rdx_r[RD_W-1] ? RD_W'(-rdx_r) : RD_W'(rdx_r);
  assign abs_rdy = rdy_r[RD_W-1] ? RD_W'(-rdy_r) : RD_W'(rdy_r);

  assign prod_x = $signed(cfg.plane_x) * cam_r;
  assign prod_y = $signed(cfg.plane_y) * cam_r;

  // distance to the first grid line along each axis, in Q.16
  assign frac_x = rdx_r[RD_W-1] ? FR_W'(cfg.pos_x[FRAC_W-1:0])
                                : FR_W'(1 << FRAC_W) - FR_W'(cfg.pos_x[FRAC_W-1:0]);
  assign frac_y = rdy_r[RD_W-1] ? FR_W'(cfg.pos_y[FRAC_W-1:0])
                                : FR_W'(1 << FRAC_W) - FR_W'(cfg.pos_y[FRAC_W-1:0]);
  assign mul_x  = frac_x * ddx_r[32:0];
  assign mul_y  = frac_y * ddy_r[32:0];

  assign pxi = cfg.pos_x[POS_W-1:FRAC_W];
  assign pyi = cfg.pos_y[POS_W-1:FRAC_W];

  // perpendicular numerator: crossed grid line minus position
  assign pn_x = PN_W'({mx_r[M_W-2:0], {FRAC_W{1'b0}}}) - PN_W'(cfg.pos_x)
              + (rdx_r[RD_W-1] ? PN_W'(1 << FRAC_W) : PN_W'(0));
  assign pn_y = PN_W'({my_r[M_W-2:0], {FRAC_W{1'b0}}}) - PN_W'(cfg.pos_y)
              + (rdy_r[RD_W-1] ? PN_W'(1 << FRAC_W) : PN_W'(0));
  assign pn_sel = side_r ? pn_y : pn_x;
  assign rd_sel = side_r ? rdy_r : rdx_r;
  assign pn_abs = pn_sel[PN_W-1] ? PN_W'(-pn_sel) : PN_W'(pn_sel);

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd.div_sel)
      DS_DDX: begin
        div_num = NUM_W'(1) << 32;
        div_den = DEN_W'(abs_rdx);
      end
      DS_DDY: begin
        div_num = NUM_W'(1) << 32;
        div_den = DEN_W'(abs_rdy);
      end
      DS_PERP: begin
        div_num = NUM_W'(pn_abs) << FRAC_W;
        div_den = side_r ? DEN_W'(abs_rdy) : DEN_W'(abs_rdx);
      end
      DS_H: begin
        div_num = NUM_W'(SCREEN_H) << FRAC_W;
        div_den = DEN_W'(dist_r);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  assign div_start = cmd.div_start;

  grc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  always_comb begin
    if (!hit_r || rd_sel == '0) begin
      dist_nxt = DIST_SAT;
    end else if (pn_sel != '0 && (pn_sel[PN_W-1] != rd_sel[RD_W-1])) begin
      dist_nxt = '0;
    end else if (div_quo > NUM_W'(DIST_SAT)) begin
      dist_nxt = DIST_SAT;
    end else begin
      dist_nxt = div_quo[DIST_W-1:0];
    end
  end

  assign hh   = h_r >> 1;
  assign ws_w = (int'(hh) >= HALF) ? '0 : (HT_W + 1)'(HALF) - (HT_W + 1)'(hh);
  assign we_w = ((HT_W + 1)'(hh) + (HT_W + 1)'(HALF) >= (HT_W + 1)'(SCREEN_H))
              ? (HT_W + 1)'(SCREEN_H - 1) : (HT_W + 1)'(hh) + (HT_W + 1)'(HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      col_r <= in_column;
    end
    if (cmd.ld_cam) begin
      cam_r <= $signed(CAM_W'(cam_mul >> CAM_SH)) - $signed(CAM_W'(1 << FRAC_W));
    end
    if (cmd.ld_ray) begin
      rdx_r <= RD_W'($signed(cfg.dir_x)) + RD_W'(prod_x >>> FRAC_W);
      rdy_r <= RD_W'($signed(cfg.dir_y)) + RD_W'(prod_y >>> FRAC_W);
    end
    if (cmd.ld_ddx) begin
      ddx_r <= (rdx_r == '0) ? DD_W'(1) << 40 : DD_W'(div_quo);
    end
    if (cmd.ld_ddy) begin
      ddy_r <= (rdy_r == '0) ? DD_W'(1) << 40 : DD_W'(div_quo);
    end
    if (cmd.ld_sd) begin
      sdx_r  <= (rdx_r == '0) ? SD_W'(frac_x) << 24 : SD_W'(mul_x >> FRAC_W);
      sdy_r  <= (rdy_r == '0) ? SD_W'(frac_y) << 24 : SD_W'(mul_y >> FRAC_W);
      mx_r   <= $signed(M_W'(pxi));
      my_r   <= $signed(M_W'(pyi));
      esc_r  <= !((int'(pxi) < MAP_SIDE) && (int'(pyi) < MAP_SIDE));
      hit_r  <= 1'b0;
      side_r <= 1'b0;
      cnt_r  <= '0;
    end
    if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
      if (sdx_r < sdy_r) begin
        sdx_r  <= sdx_r + SD_W'(ddx_r);
        mx_r   <= rdx_r[RD_W-1] ? mx_r - $signed(M_W'(1)) : mx_r + $signed(M_W'(1));
        side_r <= 1'b0;
      end else begin
        sdy_r  <= sdy_r + SD_W'(ddy_r);
        my_r   <= rdy_r[RD_W-1] ? my_r - $signed(M_W'(1)) : my_r + $signed(M_W'(1));
        side_r <= 1'b1;
      end
    end
    if (cmd.ld_hit) begin
      hit_r <= 1'b1;
      val_r <= ram_rdata;
    end
    if (cmd.ld_dist) begin
      dist_r <= dist_nxt;
    end
    if (cmd.ld_h) begin
      h_r <= (dist_r == '0) ? HT_W'(2 * SCREEN_H) : HT_W'(div_quo);
    end
    if (cmd.ld_out) begin
      out_column <= col_r;
      hit_x      <= hit_r ? mx_r[CELL_W-1:0] : '0;
      hit_y      <= hit_r ? my_r[CELL_W-1:0] : '0;
      hit_value  <= hit_r ? val_r : '0;
      hit_side   <= hit_r & side_r;
      escaped    <= !hit_r;
      wall_dist  <= dist_r;
      wall_start <= ws_w[ROW_W-1:0];
      wall_end   <= we_w[ROW_W-1:0];
    end
  end

  assign out_valid = out_valid_r;

  assign sts.clr_last = (clr_r == AW'(DEPTH - 1));
  assign sts.div_done = div_done;
  assign sts.stop     = esc_r | (cnt_r == CNT_W'(LIMIT));
  assign sts.oob      = mx_r[M_W-1] | my_r[M_W-1]
                      | (mx_r >= $signed(M_W'(MAP_SIDE))) | (my_r >= $signed(M_W'(MAP_SIDE)));
  assign sts.cell_nz  = (ram_rdata != '0);
  assign sts.out_full = out_valid_r & ~out_ready;
endmodule

FILE: rtl/core/grc_ctrl.sv
// ----------------------------------------------------------------------------
// grc_ctrl: ray caster sequencer
// Clear sweep, map writes, cast setup, DDA walk and result hand-off.
// ----------------------------------------------------------------------------
module grc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          in_ready,
  output grc_pkg::cmd_t cmd,
  input  grc_pkg::sts_t sts
);
  import grc_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CST  = 4'd2;
  localparam logic [3:0] S_RAY  = 4'd4;
  localparam logic [3:0] S_DXG  = 4'd5;
  localparam logic [3:0] S_DDX  = 4'd6;
  localparam logic [3:0] S_DDY  = 4'd7;
  localparam logic [3:0] S_SD   = 4'd8;
  localparam logic [3:0] S_STEP = 4'd9;
  localparam logic [3:0] S_RD   = 4'd10;
  localparam logic [3:0] S_TEST = 4'd11;
  localparam logic [3:0] S_PERP = 4'd12;
  localparam logic [3:0] S_HG   = 4'd13;
  localparam logic [3:0] S_H    = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_CAST) begin
            cmd.ld_item = 1'b1;
            state_nxt   = S_CST;
          end else begin
            cmd.wr_map = 1'b1;
          end
        end
      end
      S_CST: begin
        cmd.ld_cam = 1'b1;
        state_nxt  = S_RAY;
      end
      S_RAY: begin
        cmd.ld_ray = 1'b1;
        state_nxt  = S_DXG;
      end
      S_DXG: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_DDX;
        state_nxt     = S_DDX;
      end
      S_DDX: begin
        cmd.div_sel = DS_DDY;
        if (sts.div_done) begin
          cmd.ld_ddx    = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_DDY;
        end
      end
      S_DDY: begin
        if (sts.div_done) begin
          cmd.ld_ddy = 1'b1;
          state_nxt  = S_SD;
        end
      end
      S_SD: begin
        cmd.ld_sd = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.div_sel = DS_PERP;
        if (sts.stop) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_PERP;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.div_sel = DS_PERP;
        if (sts.oob) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_PERP;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        cmd.div_sel = DS_PERP;
        if (sts.cell_nz) begin
          // latch the hit and start the perpendicular divide
          cmd.ld_hit    = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_PERP;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_PERP: begin
        cmd.div_sel = DS_PERP;
        if (sts.div_done) begin
          cmd.ld_dist   = 1'b1;
          state_nxt     = S_HG;
        end
      end
      S_HG: begin
        // start the wall height divide on the stored distance
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_H;
        state_nxt     = S_H;
      end
      S_H: begin
        cmd.div_sel = DS_H;
        if (sts.div_done) begin
          cmd.ld_h  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

FILE: rtl/core/grid_ray_caster.sv
// ----------------------------------------------------------------------------
// grid_ray_caster: DDA grid ray caster, top level
// Configuration registers, sequencer, datapath and map store.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_ch     in         valid/ready          opcode, column, cell_x, cell_y, cell_value
//  out_ch    out        valid/ready          out_column, hit_*, escaped, wall_*
//  APB       in         psel/penable/pready  paddr, pwdata, prdata
//
//  A map write is done in the idle state, which stays ready for the next item.
//  A cast runs four divides on the shared divider (step lengths, perpendicular
//  distance, wall height) and walks the map through the step, read and test
//  states for each visited cell; the map read data is registered.
//  After reset all MAP_SIDE*MAP_SIDE map cells (4096 at the default) are swept
//  to zero, and no item is taken during the sweep.
//  A result waits in the output register; the block takes the next item while
//  it waits, and only stalls a finished cast until the register is free.
// ----------------------------------------------------------------------------
module grid_ray_caster #(
  parameter int SCREEN_W = grc_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = grc_pkg::SCREEN_H_DEF,
  parameter int MAP_SIDE = grc_pkg::MAP_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  grc_in_if.sink                      in_ch,
  grc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [grc_pkg::CFG_AW-1:0]  paddr,
  input  logic [grc_pkg::CFG_DW-1:0]  pwdata,
  output logic [grc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import grc_pkg::*;

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);

  cfg_t        cfg_r;
  logic [2:0]  reg_idx;
  logic        wr_en;

  cmd_t        cmd;
  sts_t        sts;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  // Register file: a write lands at the access phase of the transfer.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_x   <= '0;
      cfg_r.pos_y   <= '0;
      cfg_r.dir_x   <= VEC_W'(65536);
      cfg_r.dir_y   <= '0;
      cfg_r.plane_x <= '0;
      cfg_r.plane_y <= VEC_W'(43254);
    end else if (wr_en) begin
      case (reg_idx)
        REG_POS_X:   cfg_r.pos_x   <= pwdata[POS_W-1:0];
        REG_POS_Y:   cfg_r.pos_y   <= pwdata[POS_W-1:0];
        REG_DIR_X:   cfg_r.dir_x   <= pwdata[VEC_W-1:0];
        REG_DIR_Y:   cfg_r.dir_y   <= pwdata[VEC_W-1:0];
        REG_PLANE_X: cfg_r.plane_x <= pwdata[VEC_W-1:0];
        REG_PLANE_Y: cfg_r.plane_y <= pwdata[VEC_W-1:0];
        default: begin
          // drop writes past the last register
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POS_X:   prdata = CFG_DW'(cfg_r.pos_x);
      REG_POS_Y:   prdata = CFG_DW'(cfg_r.pos_y);
      REG_DIR_X:   prdata = CFG_DW'(cfg_r.dir_x);
      REG_DIR_Y:   prdata = CFG_DW'(cfg_r.dir_y);
      REG_PLANE_X: prdata = CFG_DW'(cfg_r.plane_x);
      REG_PLANE_Y: prdata = CFG_DW'(cfg_r.plane_y);
      default:     prdata = '0;
    endcase
  end

  // Sequencer: owns in_ch.ready; a transfer happens only in its idle state.
  grc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: ray setup, walk, divides and the output register.
  grc_dp #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .MAP_SIDE (MAP_SIDE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg           (cfg_r),
    .in_column     (in_ch.column),
    .in_cell_x     (in_ch.cell_x),
    .in_cell_y     (in_ch.cell_y),
    .in_cell_value (in_ch.cell_value),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_column    (out_ch.out_column),
    .hit_x         (out_ch.hit_x),
    .hit_y         (out_ch.hit_y),
    .hit_value     (out_ch.hit_value),
    .hit_side      (out_ch.hit_side),
    .escaped       (out_ch.escaped),
    .wall_dist     (out_ch.wall_dist),
    .wall_start    (out_ch.wall_start),
    .wall_end      (out_ch.wall_end)
  );

  // Map store, indexed x * MAP_SIDE + y.
  grc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
endmodule
